// ----- rtl/largest_empty_square_finder_assert.svh -----
// ----------------------------------------------------------------------------
// largest empty square finder assertion macros
// shared property wrappers, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH

// consequent must hold in the same cycle
`define LESF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define LESF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lesf_pkg.sv -----
// ----------------------------------------------------------------------------
// lesf_pkg
// shared widths, register indexes, types and helpers of the square finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lesf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int CHAR_W  = 8;
  localparam int SCORE_W = 11;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_OBSTACLE_CHAR = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAP_ROWS      = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAP_COLS      = 2'd2;

  localparam logic [CHAR_W-1:0] OBSTACLE_RESET = 8'd111;

  typedef logic [SCORE_W-1:0] score_t;

  typedef struct packed {
    score_t           size;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } best_t;

  function automatic score_t min3(input score_t a, input score_t b, input score_t c);
    score_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // zero counts as one, anything past the limit counts as the limit
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/lesf_ram.sv -----
// ----------------------------------------------------------------------------
// lesf_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lesf_cell.sv -----
// ----------------------------------------------------------------------------
// lesf_cell
// score of one map cell and the running best square update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_cell import lesf_pkg::*; (
  input  logic [CHAR_W-1:0] cell_char,
  input  logic [CHAR_W-1:0] obstacle_char,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  score_t            up,
  input  score_t            left,
  input  score_t            diag,
  input  best_t             best,
  output score_t            score,
  output best_t             best_next
);

  always_comb begin
    if (cell_char == obstacle_char) begin
      score = '0;
    end else if (row == '0 || col == '0) begin
      score = SCORE_W'(1);
    end else begin
      score = min3(up, left, diag) + SCORE_W'(1);
    end
  end

  // strict compare keeps the first square in raster order on ties
  always_comb begin
    best_next = best;
    if (score > best.size) begin
      best_next.size = score;
      best_next.row  = row;
      best_next.col  = col;
    end
  end

endmodule

// ----- rtl/largest_empty_square_finder.sv -----
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// streams map characters in raster order and reports the largest free square
// ----------------------------------------------------------------------------
// usage
//   cell_char beats arrive on in_valid/in_ready, one per map cell, row by row
//   and left to right; obstacle_char, map_rows and map_cols come in through
//   the cfg_we/cfg_index/cfg_data write port; the user writes them only while
//   the block is idle, which the block does not enforce; after the last
//   cell of a map one result beat leaves on out_valid/out_ready carrying
//   square_size, top_row and left_col (all zero for a map with no free
//   cell); the block then starts the next map at row 0, column 0; throughput
//   is one cell beat per clock while no result waits in the output register;
//   a cell is registered in the input stage, where the previous-row score
//   comes out of the line buffer ram (one read and one write port); a result
//   waiting in the output register stalls the input stage, so once a cell
//   waits there in_ready drops until out_ready takes the beat; rst is
//   synchronous and clears control state and the configuration to obstacle
//   111 and a 1 x 1 map; the line buffer is not cleared, row 0 of every map
//   writes it before it is read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module largest_empty_square_finder import lesf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // cell beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAR_W-1:0]  cell_char,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCORE_W-1:0] square_size,
  output logic [ROW_W-1:0]   top_row,
  output logic [COL_W-1:0]   left_col
);

`include "largest_empty_square_finder_assert.svh"

  // configuration registers
  logic [CHAR_W-1:0] obstacle_char;
  logic [CFG_W-1:0]  map_rows;
  logic [CFG_W-1:0]  map_cols;
  logic [CFG_W-1:0]  rows_eff;
  logic [CFG_W-1:0]  cols_eff;

  // position of the next cell beat
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic             end_of_row;
  logic             end_of_map;

  // input stage
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic              s1_eor;
  logic              s1_eom;
  logic              s1_fire;
  logic              in_fire;

  // scores and best square
  score_t    left_score;
  score_t    diag_score;
  best_t     best;
  best_t     best_next;
  score_t    score;
  score_t    up;
  score_t    ram_rdata;
  logic [COL_W-1:0] ram_raddr;
  logic      byp;
  score_t    byp_score;
  logic [ROW_W-1:0] top_next;
  logic [COL_W-1:0] left_next;

  assign rows_eff = clamp_size(map_rows, CFG_W'(MAX_ROWS));
  assign cols_eff = clamp_size(map_cols, CFG_W'(MAX_COLS));

  assign end_of_row = ({1'b0, col_count} + CFG_W'(1)) >= cols_eff;
  assign end_of_map = ({1'b0, row_count} + CFG_W'(1)) >= rows_eff;

  // the stage moves on unless a result still waits in the output register
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_char <= OBSTACLE_RESET;
      map_rows      <= CFG_W'(1);
      map_cols      <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBSTACLE_CHAR: obstacle_char <= cfg_data[CHAR_W-1:0];
        REG_MAP_ROWS:      map_rows      <= cfg_data;
        REG_MAP_COLS:      map_cols      <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position, advanced as each beat enters the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_fire) begin
      if (end_of_row) begin
        col_count <= '0;
        row_count <= end_of_map ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char <= cell_char;
      s1_row  <= row_count;
      s1_col  <= col_count;
      s1_eor  <= end_of_row;
      s1_eom  <= end_of_row && end_of_map;
    end
  end

  // line buffer: read the column of the incoming beat, or keep rereading
  // the column of the beat that waits in the stage
  assign ram_raddr = in_fire ? col_count : s1_col;

  lesf_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (score),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a one-column map reads the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= s1_fire && in_fire && (col_count == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    byp_score <= score;
  end

  assign up = byp ? byp_score : ram_rdata;

  lesf_cell u_cell (
    .cell_char     (s1_char),
    .obstacle_char (obstacle_char),
    .row           (s1_row),
    .col           (s1_col),
    .up            (up),
    .left          (left_score),
    .diag          (diag_score),
    .best          (best),
    .score         (score),
    .best_next     (best_next)
  );

  // top-left corner from the bottom-right corner of the best square
  always_comb begin
    top_next  = '0;
    left_next = '0;
    if (best_next.size != '0) begin
      top_next  = ROW_W'({1'b0, best_next.row} + SCORE_W'(1) - best_next.size);
      left_next = COL_W'({1'b0, best_next.col} + SCORE_W'(1) - best_next.size);
    end
  end

  // neighbor scores and best square, reset at row and map boundaries
  always_ff @(posedge clk) begin
    if (rst) begin
      left_score <= '0;
      diag_score <= '0;
      best       <= '0;
    end else if (s1_fire) begin
      if (s1_eor) begin
        left_score <= '0;
        diag_score <= '0;
      end else begin
        left_score <= score;
        diag_score <= up;
      end
      best <= s1_eom ? '0 : best_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_eom) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_eom) begin
      square_size <= best_next.size;
      top_row     <= top_next;
      left_col    <= left_next;
    end
  end

  // checks
  `LESF_ASSERT_NEXT(a_eom_gives_result, s1_fire && s1_eom, out_valid, "map end without result")
  `LESF_ASSERT_SAME(a_empty_at_origin, out_valid && square_size == '0, top_row == '0 && left_col == '0, "empty map not at origin")
  `LESF_ASSERT_SAME(a_bypass_has_beat, byp, s1_valid, "line buffer bypass with empty stage")
  `LESF_ASSERT_SAME(a_held_result_stalls, out_valid && !out_ready && s1_valid, !in_ready, "input over held result")

endmodule

// ----- tb/lesf_checker.sv -----
// ----------------------------------------------------------------------------
// lesf_checker
// watches the cell, result and register ports of the square finder, keeps
// its own line of scores and compares every result beat with the square it owes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_checker import lesf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CHAR_W-1:0]  cell_char,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [SCORE_W-1:0] square_size,
  input  logic [ROW_W-1:0]   top_row,
  input  logic [COL_W-1:0]   left_col,
  output int                 fail_count,
  output int                 pending
);

  logic [CHAR_W-1:0] obst_code;
  logic [CFG_W-1:0]  rows_set;
  logic [CFG_W-1:0]  cols_set;

  score_t line_buf [MAX_COLS];
  score_t left_nb;
  score_t diag_nb;
  int     row_at;
  int     col_at;
  best_t  best;          // size plus bottom-right corner
  best_t  squares_due [$];
  int     errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int extent(input logic [CFG_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic void score_cell(input logic [CHAR_W-1:0] ch);
    int     rows_e;
    int     cols_e;
    score_t up;
    score_t s;
    score_t m;
    best_t  done;
    rows_e = extent(rows_set, MAX_ROWS);
    cols_e = extent(cols_set, MAX_COLS);
    up = line_buf[col_at];
    if (ch == obst_code) begin
      s = '0;
    end else if (row_at == 0 || col_at == 0) begin
      s = score_t'(1);
    end else begin
      m = (up < left_nb) ? up : left_nb;
      if (diag_nb < m) m = diag_nb;
      s = m + score_t'(1);
    end
    diag_nb = up;
    left_nb = s;
    line_buf[col_at] = s;
    // strict compare keeps the first square in raster order on a tie
    if (s > best.size) begin
      best.size = s;
      best.row  = ROW_W'(row_at);
      best.col  = COL_W'(col_at);
    end
    if (col_at + 1 >= cols_e) begin
      col_at  = 0;
      left_nb = '0;
      diag_nb = '0;
      if (row_at + 1 >= rows_e) begin
        done = '0;
        done.size = best.size;
        if (best.size != '0) begin
          done.row = ROW_W'(best.row + 11'd1 - best.size);
          done.col = COL_W'(best.col + 11'd1 - best.size);
        end
        squares_due.push_back(done);
        row_at = 0;
        best   = '0;
      end else begin
        row_at++;
      end
    end else begin
      col_at++;
    end
  endfunction

  always @(posedge clk) begin : watch
    best_t due;
    if (rst) begin
      obst_code = OBSTACLE_RESET;
      rows_set  = CFG_W'(1);
      cols_set  = CFG_W'(1);
      foreach (line_buf[i]) line_buf[i] = '0;
      left_nb = '0;
      diag_nb = '0;
      row_at  = 0;
      col_at  = 0;
      best    = '0;
      squares_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OBSTACLE_CHAR: obst_code = cfg_data[CHAR_W-1:0];
          REG_MAP_ROWS:      rows_set  = cfg_data;
          REG_MAP_COLS:      cols_set  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) score_cell(cell_char);
      if (out_valid && out_ready) begin
        if (squares_due.size() == 0) begin
          $display("%0t ns: result beat expected none, got size %0d row %0d col %0d",
                   $time, square_size, top_row, left_col);
          errors++;
        end else begin
          due = squares_due.pop_front();
          if (square_size !== due.size) begin
            $display("%0t ns: square_size expected %0d, got %0d", $time, due.size, square_size);
            errors++;
          end
          if (top_row !== due.row) begin
            $display("%0t ns: top_row expected %0d, got %0d", $time, due.row, top_row);
            errors++;
          end
          if (left_col !== due.col) begin
            $display("%0t ns: left_col expected %0d, got %0d", $time, due.col, left_col);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= squares_due.size();
  end

endmodule

// ----- tb/tb_largest_empty_square_finder.sv -----
// ----------------------------------------------------------------------------
// tb_largest_empty_square_finder
// drives map cells and register writes into the square finder with random
// gaps and output stalls; a side checker predicts every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_largest_empty_square_finder;
  import lesf_pkg::*;

  // index 3 has no register behind it, writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int STALL_LIMIT  = 2000;  // cycles with no beat and no write
  localparam int RANDOM_CELLS = 1950;  // the random part runs until this many cells
  localparam int CALM_AFTER   = 1650;  // no idling on either side past this
  localparam int LONE_AT      = 300;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic [CHAR_W-1:0]  cell_char = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [SCORE_W-1:0] square_size;
  logic [ROW_W-1:0]   top_row;
  logic [COL_W-1:0]   left_col;

  int fail_count;
  int pending;

  bit calm         = 1'b0;
  int ready_hold   = 0;
  int stall_cycles = 0;

  // register values as last written, for sizing the cell stream
  logic [CHAR_W-1:0] obst_now = OBSTACLE_RESET;
  logic [CFG_W-1:0]  rows_now = CFG_W'(1);
  logic [CFG_W-1:0]  cols_now = CFG_W'(1);

  largest_empty_square_finder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_char  (cell_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .square_size(square_size),
    .top_row    (top_row),
    .left_col   (left_col)
  );

  lesf_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_char  (cell_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .square_size(square_size),
    .top_row    (top_row),
    .left_col   (left_col),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall bursts, long open stretches between
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) out_ready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(1, 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: any beat or register write counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** largest_empty_square_finder: FAILED **");
      $finish;
    end
  end

  // one cell beat; an optional gap first, then hold valid until taken
  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_char <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every owed result beat is out and the pipe drains
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // cfg_we is left high across back-to-back writes, lowered by configure
  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // pick bit i writes register i; bit 3 pokes the spare index with junk
  task automatic configure(input logic [CHAR_W-1:0] obst, input logic [CFG_W-1:0] rows,
                           input logic [CFG_W-1:0] cols, input logic [3:0] pick);
    if (pick[0]) begin
      // upper data bits are junk for the 8-bit register
      put_reg(REG_OBSTACLE_CHAR, {(CFG_W-CHAR_W)'($urandom), obst});
      obst_now = obst;
    end
    if (pick[1]) begin
      put_reg(REG_MAP_ROWS, rows);
      rows_now = rows;
    end
    if (pick[2]) begin
      put_reg(REG_MAP_COLS, cols);
      cols_now = cols;
    end
    if (pick[3]) put_reg(REG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // zero reads as one, oversize reads as the limit
  function automatic int map_cells();
    int r;
    int c;
    r = (rows_now == '0) ? 1 : (rows_now > MAX_ROWS) ? MAX_ROWS : int'(rows_now);
    c = (cols_now == '0) ? 1 : (cols_now > MAX_COLS) ? MAX_COLS : int'(cols_now);
    return r * c;
  endfunction

  function automatic logic [CFG_W-1:0] pick_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'($urandom_range(9, 12));
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  // oversize map, obstacles everywhere but the very last cell, so the
  // square lands on the far edge of the position range
  task automatic lone_cell_map(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    int n;
    logic [CHAR_W-1:0] obst;
    obst = CHAR_W'($urandom);
    wait_idle();
    configure(obst, rows, cols, 4'b0111);
    n = map_cells();
    for (int k = 0; k < n; k++) begin
      send_cell((k == n - 1) ? obst + CHAR_W'($urandom_range(1, 255)) : obst);
    end
  endtask

  initial begin
    int n;
    int pct;
    int small_cells;
    bit lone_done;
    logic [CHAR_W-1:0] obst;
    logic [CFG_W-1:0]  rows;
    logic [CFG_W-1:0]  cols;
    string tie_map;

    small_cells = 0;
    lone_done   = 1'b0;
    tie_map     = "..o....o..";

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // reset settings: 1 x 1 map, obstacle 'o'
    wait_idle();
    send_cell(OBSTACLE_RESET);       // all-obstacle map, size 0 at the origin
    send_cell(8'h00);                // single free cell
    // zero sizes read as 1 x 1, lowest obstacle code, spare index poked
    wait_idle();
    configure(8'h00, '0, '0, 4'b1111);
    send_cell(8'h00);
    send_cell(8'hff);
    // highest obstacle code, fully free 3 x 3
    wait_idle();
    configure(8'hff, CFG_W'(3), CFG_W'(3), 4'b0111);
    for (int k = 0; k < 9; k++) send_cell(CHAR_W'($urandom_range(0, 254)));
    // two equal 2 x 2 squares, the first one in raster order wins
    wait_idle();
    configure(OBSTACLE_RESET, CFG_W'(2), CFG_W'(5), 4'b0111);
    for (int k = 0; k < tie_map.len(); k++) send_cell(tie_map[k]);

    // ---- random part ----
    while (small_cells < RANDOM_CELLS) begin
      if (!lone_done && small_cells >= LONE_AT) begin
        // one oversize map, either too many rows or too many columns
        if ($urandom_range(0, 1) == 0) begin
          lone_cell_map({CFG_W{1'b1}}, CFG_W'(1));
        end else begin
          lone_cell_map('0, CFG_W'($urandom_range(MAX_COLS + 1, 2047)));
        end
        small_cells += map_cells();
        lone_done = 1'b1;
      end else begin
        calm = (small_cells >= CALM_AFTER);
        // calm maps reuse the last settings and follow with no gap
        if (!calm) begin
          obst = ($urandom_range(0, 2) == 0) ? OBSTACLE_RESET : CHAR_W'($urandom);
          rows = pick_side();
          cols = pick_side();
          wait_idle();
          configure(obst, rows, cols, 4'($urandom));
        end
        n = map_cells();
        // obstacle density per map, empty and solid maps now and then
        case ($urandom_range(0, 5))
          0:       pct = 0;
          1:       pct = 100;
          default: pct = $urandom_range(0, 60);
        endcase
        for (int k = 0; k < n; k++) begin
          send_cell(($urandom_range(0, 99) < pct) ? obst_now : CHAR_W'($urandom));
        end
        small_cells += n;
      end
    end

    // drain: everything owed, then a wait for stray beats
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** largest_empty_square_finder: PASSED **");
    end else begin
      $display("** largest_empty_square_finder: FAILED **");
    end
    $finish;
  end

endmodule
